// ===== rtl/core/cpu8alu_pkg.sv =====
// Package: operation codes and widths for the 8-bit ALU execute block.
package cpu8alu_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned ActW   = 5;
	localparam int unsigned ApbW   = 32;
	localparam int unsigned PaddrW = 3;

	typedef enum logic [ActW-1:0] {
		ACT_ORA = 5'd0,
		ACT_AND = 5'd1,
		ACT_EOR = 5'd2,
		ACT_ADC = 5'd3,
		ACT_STA = 5'd4,
		ACT_LDA = 5'd5,
		ACT_CMP = 5'd6,
		ACT_SBC = 5'd7,
		ACT_ASL = 5'd8,
		ACT_ROL = 5'd9,
		ACT_LSR = 5'd10,
		ACT_ROR = 5'd11,
		ACT_STX = 5'd12,
		ACT_LDX = 5'd13,
		ACT_DEC = 5'd14,
		ACT_INC = 5'd15,
		ACT_BIT = 5'd16,
		ACT_STY = 5'd17,
		ACT_LDY = 5'd18,
		ACT_CPY = 5'd19,
		ACT_CPX = 5'd20
	} action_t;

	typedef enum logic [0:0] {
		REG_DECIMAL_MODE = 1'b0
	} reg_idx_t;

endpackage

// ===== rtl/core/cpu8_alu_register_execute_top.sv =====
// Top level: 8-bit accumulator ALU execute block with A/X/Y and N/Z/C/V state.
//
// Accepts one word per clock while item_stall is low and returns one result word
// per input word via the input and result registers. The operation runs in
// one pass of logic between the input register and the result register; A, X,
// Y and the flags update as a word moves from the input register to the result
// register, so each word sees the state left by the one before it. The input
// stalls only when both registers hold words and the output is stalled. The
// decimal_mode register (byte address 0, bit 0) selects packed BCD for ADC and
// SBC and should be written only while the block is idle.
module cpu8_alu_register_execute_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cpu8alu_pkg::PaddrW-1:0]      paddr,
	input  logic [cpu8alu_pkg::ApbW-1:0]        pwdata,
	output logic [cpu8alu_pkg::ApbW-1:0]        prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [cpu8alu_pkg::ActW-1:0]        action,
	input  logic [cpu8alu_pkg::ByteW-1:0]       operand,
	input  logic                                to_accumulator,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [cpu8alu_pkg::ByteW-1:0]       acc_out,
	output logic [cpu8alu_pkg::ByteW-1:0]       x_out,
	output logic [cpu8alu_pkg::ByteW-1:0]       y_out,
	output logic                                flag_neg,
	output logic                                flag_zero,
	output logic                                flag_carry,
	output logic                                flag_ovf,
	output logic [cpu8alu_pkg::ByteW-1:0]       store_data,
	output logic                                store_valid
);

	logic decimal_q;
	logic reg_sel;

	logic                              valid_s1;
	cpu8alu_pkg::action_t              action_s1;
	logic [cpu8alu_pkg::ByteW-1:0]     operand_s1;
	logic                              to_acc_s1;

	logic                              valid_s2;
	logic [cpu8alu_pkg::ByteW-1:0]     acc_s2, x_s2, y_s2, sdata_s2;
	logic                              n_s2, z_s2, c_s2, v_s2, svalid_s2;

	logic [cpu8alu_pkg::ByteW-1:0]     acc_q, x_q, y_q;
	logic                              n_q, z_q, c_q, v_q;

	logic load_s2, load_s1;

	logic [cpu8alu_pkg::ByteW-1:0] acc_d, x_d, y_d, sdata_d;
	logic                          n_d, z_d, c_d, v_d, svalid_d;

	logic [cpu8alu_pkg::ByteW-1:0] m, mb, bres, shv, shr, cmp_reg, cmp_diff, nz_val;
	logic [cpu8alu_pkg::ByteW:0]   bsum;
	logic                          is_sub, ovf, cin, set_nz_en;
	logic [4:0]                    add_lo, add_hi;
	logic                          add_lc, add_c;
	logic [3:0]                    add_lo_n, add_hi_n;
	logic [5:0]                    sub_lo, sub_hi;
	logic                          sub_lb;
	logic [3:0]                    sub_lo_n, sub_hi_n;
	logic [cpu8alu_pkg::ByteW-1:0] as_res;
	logic                          as_carry;

	assign reg_sel = (paddr[cpu8alu_pkg::PaddrW-1] == 1'(cpu8alu_pkg::REG_DECIMAL_MODE));
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(cpu8alu_pkg::ApbW-1){1'b0}}, decimal_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimal_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			decimal_q <= pwdata[0];
		end
	end

	assign load_s2    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && valid_s2 && result_stall;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1  <= cpu8alu_pkg::action_t'(action);
			operand_s1 <= operand;
			to_acc_s1  <= to_accumulator;
		end
	end

	always_comb begin
		m        = operand_s1;
		cin      = c_q;
		is_sub   = (action_s1 == cpu8alu_pkg::ACT_SBC);
		mb       = is_sub ? ~m : m;
		bsum     = {1'b0, acc_q} + {1'b0, mb} + {{cpu8alu_pkg::ByteW{1'b0}}, cin};
		bres     = bsum[cpu8alu_pkg::ByteW-1:0];
		ovf      = (~(acc_q[7] ^ mb[7])) & (acc_q[7] ^ bres[7]);

		add_lo   = {1'b0, acc_q[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
		add_lc   = (add_lo > 5'd9);
		add_lo_n = add_lc ? (add_lo[3:0] + 4'd6) : add_lo[3:0];
		add_hi   = {1'b0, acc_q[7:4]} + {1'b0, m[7:4]} + {4'd0, add_lc};
		add_c    = (add_hi > 5'd9);
		add_hi_n = add_c ? (add_hi[3:0] + 4'd6) : add_hi[3:0];

		sub_lo   = {2'b00, acc_q[3:0]} - {2'b00, m[3:0]} - {5'd0, !cin};
		sub_lb   = sub_lo[5];
		sub_lo_n = sub_lb ? (sub_lo[3:0] - 4'd6) : sub_lo[3:0];
		sub_hi   = {2'b00, acc_q[7:4]} - {2'b00, m[7:4]} - {5'd0, sub_lb};
		sub_hi_n = sub_hi[5] ? (sub_hi[3:0] - 4'd6) : sub_hi[3:0];

		if (!decimal_q) begin
			as_res   = bres;
			as_carry = bsum[cpu8alu_pkg::ByteW];
		end else if (!is_sub) begin
			as_res   = {add_hi_n, add_lo_n};
			as_carry = add_c;
		end else begin
			as_res   = {sub_hi_n, sub_lo_n};
			as_carry = !sub_hi[5];
		end

		shv = to_acc_s1 ? acc_q : m;
		case (action_s1)
			cpu8alu_pkg::ACT_ASL: shr = {shv[6:0], 1'b0};
			cpu8alu_pkg::ACT_ROL: shr = {shv[6:0], cin};
			cpu8alu_pkg::ACT_LSR: shr = {1'b0, shv[7:1]};
			default:              shr = {cin, shv[7:1]};
		endcase

		case (action_s1)
			cpu8alu_pkg::ACT_CPX: cmp_reg = x_q;
			cpu8alu_pkg::ACT_CPY: cmp_reg = y_q;
			default:              cmp_reg = acc_q;
		endcase
		cmp_diff = cmp_reg - m;

		acc_d     = acc_q;
		x_d       = x_q;
		y_d       = y_q;
		n_d       = n_q;
		z_d       = z_q;
		c_d       = c_q;
		v_d       = v_q;
		sdata_d   = '0;
		svalid_d  = 1'b0;
		nz_val    = '0;
		set_nz_en = 1'b0;

		case (action_s1)
			cpu8alu_pkg::ACT_ORA: begin
				acc_d = acc_q | m; nz_val = acc_d; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_AND: begin
				acc_d = acc_q & m; nz_val = acc_d; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_EOR: begin
				acc_d = acc_q ^ m; nz_val = acc_d; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_ADC, cpu8alu_pkg::ACT_SBC: begin
				acc_d = as_res; c_d = as_carry; v_d = ovf;
				nz_val = as_res; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_STA: begin
				sdata_d = acc_q; svalid_d = 1'b1;
			end
			cpu8alu_pkg::ACT_STX: begin
				sdata_d = x_q; svalid_d = 1'b1;
			end
			cpu8alu_pkg::ACT_STY: begin
				sdata_d = y_q; svalid_d = 1'b1;
			end
			cpu8alu_pkg::ACT_LDA: begin
				acc_d = m; nz_val = m; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_LDX: begin
				x_d = m; nz_val = m; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_LDY: begin
				y_d = m; nz_val = m; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_CMP, cpu8alu_pkg::ACT_CPX, cpu8alu_pkg::ACT_CPY: begin
				c_d = (cmp_reg >= m); nz_val = cmp_diff; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_ASL, cpu8alu_pkg::ACT_ROL: begin
				c_d = shv[7]; nz_val = shr; set_nz_en = 1'b1;
				if (to_acc_s1) begin
					acc_d = shr;
				end else begin
					sdata_d = shr; svalid_d = 1'b1;
				end
			end
			cpu8alu_pkg::ACT_LSR, cpu8alu_pkg::ACT_ROR: begin
				c_d = shv[0]; nz_val = shr; set_nz_en = 1'b1;
				if (to_acc_s1) begin
					acc_d = shr;
				end else begin
					sdata_d = shr; svalid_d = 1'b1;
				end
			end
			cpu8alu_pkg::ACT_DEC: begin
				sdata_d = m - 8'd1; svalid_d = 1'b1; nz_val = sdata_d; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_INC: begin
				sdata_d = m + 8'd1; svalid_d = 1'b1; nz_val = sdata_d; set_nz_en = 1'b1;
			end
			cpu8alu_pkg::ACT_BIT: begin
				n_d = m[7]; v_d = m[6]; z_d = ((acc_q & m) == '0);
			end
			default: begin
			end
		endcase

		if (set_nz_en) begin
			n_d = nz_val[7];
			z_d = (nz_val == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			x_q   <= '0;
			y_q   <= '0;
			n_q   <= 1'b0;
			z_q   <= 1'b0;
			c_q   <= 1'b0;
			v_q   <= 1'b0;
		end else if (load_s2) begin
			acc_q <= acc_d;
			x_q   <= x_d;
			y_q   <= y_d;
			n_q   <= n_d;
			z_q   <= z_d;
			c_q   <= c_d;
			v_q   <= v_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			acc_s2    <= acc_d;
			x_s2      <= x_d;
			y_s2      <= y_d;
			n_s2      <= n_d;
			z_s2      <= z_d;
			c_s2      <= c_d;
			v_s2      <= v_d;
			sdata_s2  <= sdata_d;
			svalid_s2 <= svalid_d;
		end
	end

	assign result_valid = valid_s2;
	assign acc_out      = acc_s2;
	assign x_out        = x_s2;
	assign y_out        = y_s2;
	assign flag_neg     = n_s2;
	assign flag_zero    = z_s2;
	assign flag_carry   = c_s2;
	assign flag_ovf     = v_s2;
	assign store_data   = sdata_s2;
	assign store_valid  = svalid_s2;

endmodule

// ===== rtl/core/cpu8alu_checker.sv =====
// Checker: port-level properties of the ALU execute block, bound to the top level.
module cpu8alu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                pready,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic [cpu8alu_pkg::ByteW-1:0]       acc_out,
	input logic [cpu8alu_pkg::ByteW-1:0]       store_data,
	input logic                                store_valid
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result word shown during reset");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled while result side can move");

	a_no_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !store_valid) |-> (store_data == '0))
		else $error("store data nonzero without store");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(acc_out)
			&& $stable(store_data) && $stable(store_valid)))
		else $error("stalled result word changed");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind cpu8_alu_register_execute_top cpu8alu_checker u_cpu8alu_checker (.*);

// ===== bench/cpu8_alu_register_execute_checker.sv =====
// Checker: predicts each result word of the 8-bit ALU execute block and compares it with the outputs.
module cpu8_alu_register_execute_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [cpu8alu_pkg::PaddrW-1:0]      paddr,
	input  logic [cpu8alu_pkg::ApbW-1:0]        pwdata,
	input  logic                                item_valid,
	input  logic                                item_stall,
	input  logic [cpu8alu_pkg::ActW-1:0]        action,
	input  logic [cpu8alu_pkg::ByteW-1:0]       operand,
	input  logic                                to_accumulator,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [cpu8alu_pkg::ByteW-1:0]       acc_out,
	input  logic [cpu8alu_pkg::ByteW-1:0]       x_out,
	input  logic [cpu8alu_pkg::ByteW-1:0]       y_out,
	input  logic                                flag_neg,
	input  logic                                flag_zero,
	input  logic                                flag_carry,
	input  logic                                flag_ovf,
	input  logic [cpu8alu_pkg::ByteW-1:0]       store_data,
	input  logic                                store_valid,
	output int unsigned                         mismatches,
	output int unsigned                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BcdMaxDigit = 9;
	localparam int BcdAdjust   = 6;

	typedef struct packed {
		logic [cpu8alu_pkg::ByteW-1:0] acc;
		logic [cpu8alu_pkg::ByteW-1:0] x;
		logic [cpu8alu_pkg::ByteW-1:0] y;
		logic                          n;
		logic                          z;
		logic                          c;
		logic                          v;
		logic [cpu8alu_pkg::ByteW-1:0] sdata;
		logic                          svalid;
	} cpu_state_word_t;

	logic [cpu8alu_pkg::ByteW-1:0] st_a, st_x, st_y;
	logic                          st_n, st_z, st_c, st_v;
	logic                          bcd_mode;
	cpu_state_word_t               predicted_words[$];

	task automatic set_nz(input logic [cpu8alu_pkg::ByteW-1:0] val);
		st_n = val[cpu8alu_pkg::ByteW-1];
		st_z = (val == '0);
	endtask

	task automatic compare_reg(input logic [cpu8alu_pkg::ByteW-1:0] lhs,
			input logic [cpu8alu_pkg::ByteW-1:0] m);
		st_c = (lhs >= m);
		set_nz(lhs - m);
	endtask

	task automatic alu_execute(input logic [cpu8alu_pkg::ActW-1:0] act,
			input logic [cpu8alu_pkg::ByteW-1:0] m,
			input logic to_acc, output cpu_state_word_t r);
		logic [cpu8alu_pkg::ByteW-1:0] v, mb, bres, res, sdata;
		logic [cpu8alu_pkg::ByteW:0]   bsum;
		logic [4:0]                    lo_sum, hi_sum;
		int                            lo_dif, hi_dif;
		logic                          sv, cout, ovf, lc, lb;
		sdata = '0;
		sv = 1'b0;
		case (act)
			cpu8alu_pkg::ACT_ORA: begin
				st_a = st_a | m;
				set_nz(st_a);
			end
			cpu8alu_pkg::ACT_AND: begin
				st_a = st_a & m;
				set_nz(st_a);
			end
			cpu8alu_pkg::ACT_EOR: begin
				st_a = st_a ^ m;
				set_nz(st_a);
			end
			cpu8alu_pkg::ACT_ADC, cpu8alu_pkg::ACT_SBC: begin
				mb = (act == cpu8alu_pkg::ACT_SBC) ? ~m : m;
				bsum = {1'b0, st_a} + {1'b0, mb} + (cpu8alu_pkg::ByteW+1)'(st_c);
				bres = bsum[cpu8alu_pkg::ByteW-1:0];
				ovf = ~(st_a[7] ^ mb[7]) & (st_a[7] ^ bres[7]);
				if (!bcd_mode) begin
					res = bres;
					cout = bsum[cpu8alu_pkg::ByteW];
				end else if (act == cpu8alu_pkg::ACT_ADC) begin
					lo_sum = {1'b0, st_a[3:0]} + {1'b0, m[3:0]} + 5'(st_c);
					lc = (lo_sum > BcdMaxDigit);
					if (lc) begin
						lo_sum = 5'((lo_sum + BcdAdjust) & 5'hF);
					end
					hi_sum = {1'b0, st_a[7:4]} + {1'b0, m[7:4]} + 5'(lc);
					cout = (hi_sum > BcdMaxDigit);
					if (cout) begin
						hi_sum = 5'((hi_sum + BcdAdjust) & 5'hF);
					end
					res = {hi_sum[3:0], lo_sum[3:0]};
				end else begin
					lo_dif = int'(st_a[3:0]) - int'(m[3:0]) - (st_c ? 0 : 1);
					lb = (lo_dif < 0);
					if (lb) begin
						lo_dif -= BcdAdjust;
					end
					hi_dif = int'(st_a[7:4]) - int'(m[7:4]) - (lb ? 1 : 0);
					cout = (hi_dif >= 0);
					if (!cout) begin
						hi_dif -= BcdAdjust;
					end
					res = {hi_dif[3:0], lo_dif[3:0]};
				end
				st_a = res;
				st_c = cout;
				st_v = ovf;
				set_nz(res);
			end
			cpu8alu_pkg::ACT_STA: begin
				sdata = st_a;
				sv = 1'b1;
			end
			cpu8alu_pkg::ACT_LDA: begin
				st_a = m;
				set_nz(m);
			end
			cpu8alu_pkg::ACT_CMP: compare_reg(st_a, m);
			cpu8alu_pkg::ACT_ASL, cpu8alu_pkg::ACT_ROL, cpu8alu_pkg::ACT_LSR,
					cpu8alu_pkg::ACT_ROR: begin
				v = to_acc ? st_a : m;
				if (act == cpu8alu_pkg::ACT_ASL || act == cpu8alu_pkg::ACT_ROL) begin
					cout = v[7];
					res = {v[6:0], (act == cpu8alu_pkg::ACT_ROL) ? st_c : 1'b0};
				end else begin
					cout = v[0];
					res = {(act == cpu8alu_pkg::ACT_ROR) ? st_c : 1'b0, v[7:1]};
				end
				st_c = cout;
				set_nz(res);
				if (to_acc) begin
					st_a = res;
				end else begin
					sdata = res;
					sv = 1'b1;
				end
			end
			cpu8alu_pkg::ACT_STX: begin
				sdata = st_x;
				sv = 1'b1;
			end
			cpu8alu_pkg::ACT_LDX: begin
				st_x = m;
				set_nz(m);
			end
			cpu8alu_pkg::ACT_DEC: begin
				sdata = m - 8'd1;
				sv = 1'b1;
				set_nz(sdata);
			end
			cpu8alu_pkg::ACT_INC: begin
				sdata = m + 8'd1;
				sv = 1'b1;
				set_nz(sdata);
			end
			cpu8alu_pkg::ACT_BIT: begin
				st_n = m[7];
				st_v = m[6];
				st_z = ((st_a & m) == '0);
			end
			cpu8alu_pkg::ACT_STY: begin
				sdata = st_y;
				sv = 1'b1;
			end
			cpu8alu_pkg::ACT_LDY: begin
				st_y = m;
				set_nz(m);
			end
			cpu8alu_pkg::ACT_CPY: compare_reg(st_y, m);
			cpu8alu_pkg::ACT_CPX: compare_reg(st_x, m);
			default: ;
		endcase
		r.acc = st_a;
		r.x = st_x;
		r.y = st_y;
		r.n = st_n;
		r.z = st_z;
		r.c = st_c;
		r.v = st_v;
		r.sdata = sv ? sdata : '0;
		r.svalid = sv;
	endtask

	task automatic check_field(input string name, input logic [cpu8alu_pkg::ByteW-1:0] want,
			input logic [cpu8alu_pkg::ByteW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cpu_state_word_t want, got;
		if (!arst_n) begin
			st_a = '0;
			st_x = '0;
			st_y = '0;
			{st_n, st_z, st_c, st_v} = '0;
			bcd_mode = 1'b0;
			predicted_words.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
					&& paddr[cpu8alu_pkg::PaddrW-1:2] == cpu8alu_pkg::REG_DECIMAL_MODE) begin
				bcd_mode = pwdata[0];
			end
			if (result_valid && !result_stall) begin
				if (predicted_words.size() == 0) begin
					$display("%0t: unexpected result word: expected none, actual acc %02h x %02h y %02h",
						$time, acc_out, x_out, y_out);
					mismatches++;
				end else begin
					want = predicted_words.pop_front();
					check_field("acc_out", want.acc, acc_out);
					check_field("x_out", want.x, x_out);
					check_field("y_out", want.y, y_out);
					check_field("flag_neg", cpu8alu_pkg::ByteW'(want.n),
						cpu8alu_pkg::ByteW'(flag_neg));
					check_field("flag_zero", cpu8alu_pkg::ByteW'(want.z),
						cpu8alu_pkg::ByteW'(flag_zero));
					check_field("flag_carry", cpu8alu_pkg::ByteW'(want.c),
						cpu8alu_pkg::ByteW'(flag_carry));
					check_field("flag_ovf", cpu8alu_pkg::ByteW'(want.v),
						cpu8alu_pkg::ByteW'(flag_ovf));
					check_field("store_data", want.sdata, store_data);
					check_field("store_valid", cpu8alu_pkg::ByteW'(want.svalid),
						cpu8alu_pkg::ByteW'(store_valid));
				end
			end
			if (item_valid && !item_stall) begin
				alu_execute(action, operand, to_accumulator, got);
				predicted_words.push_back(got);
			end
		end
		pending = predicted_words.size();
	end

endmodule

// ===== bench/tb_cpu8_alu_register_execute_top.sv =====
// Testbench top: drives words and register writes into the ALU execute block and reports the verdict.
module tb_cpu8_alu_register_execute_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [cpu8alu_pkg::PaddrW-1:0]  paddr;
	logic [cpu8alu_pkg::ApbW-1:0]    pwdata;
	logic [cpu8alu_pkg::ApbW-1:0]    prdata;
	logic                            pready;
	logic                            item_valid;
	logic                            item_stall;
	logic [cpu8alu_pkg::ActW-1:0]    action;
	logic [cpu8alu_pkg::ByteW-1:0]   operand;
	logic                            to_accumulator;
	logic                            result_valid;
	logic                            result_stall;
	logic [cpu8alu_pkg::ByteW-1:0]   acc_out;
	logic [cpu8alu_pkg::ByteW-1:0]   x_out;
	logic [cpu8alu_pkg::ByteW-1:0]   y_out;
	logic                            flag_neg;
	logic                            flag_zero;
	logic                            flag_carry;
	logic                            flag_ovf;
	logic [cpu8alu_pkg::ByteW-1:0]   store_data;
	logic                            store_valid;
	int unsigned                     mismatches;
	int unsigned                     pending;
	bit                              sender_idle_on;
	bit                              receiver_idle_on;

	cpu8_alu_register_execute_top dut (.*);

	cpu8_alu_register_execute_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int burst;
		burst = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				burst--;
			end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 15);
			end
			result_stall = (burst > 0);
		end
	end

	task automatic reg_write(input cpu8alu_pkg::reg_idx_t idx,
			input logic [cpu8alu_pkg::ApbW-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = cpu8alu_pkg::PaddrW'(int'(idx) * 4);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_word(input logic [cpu8alu_pkg::ActW-1:0] act,
			input logic [cpu8alu_pkg::ByteW-1:0] m, input logic to_acc);
		if (sender_idle_on && $urandom_range(0, 5) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_valid = 1'b1;
		action = act;
		operand = m;
		to_accumulator = to_acc;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic drain;
		item_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_random(input logic bcd);
		logic [cpu8alu_pkg::ActW-1:0]  act;
		logic [cpu8alu_pkg::ByteW-1:0] m;
		int unsigned                   pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			act = cpu8alu_pkg::ActW'(int'(cpu8alu_pkg::ACT_CPX) + $urandom_range(1, 11));
		end else if (bcd && pick < 40) begin
			act = $urandom_range(0, 1) ? cpu8alu_pkg::ACT_ADC : cpu8alu_pkg::ACT_SBC;
		end else if (bcd && pick < 50) begin
			act = cpu8alu_pkg::ACT_LDA;
		end else begin
			act = cpu8alu_pkg::ActW'($urandom_range(0, int'(cpu8alu_pkg::ACT_CPX)));
		end
		case ($urandom_range(0, 7))
			0: m = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			1: m = $urandom_range(0, 1) ? 8'h7F : 8'h80;
			2, 3: m = bcd ? {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))}
					: 8'($urandom);
			default: m = 8'($urandom);
		endcase
		send_word(act, m, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		action = cpu8alu_pkg::ACT_ORA;
		operand = '0;
		to_accumulator = 1'b0;
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		reg_write(cpu8alu_pkg::REG_DECIMAL_MODE, '0);
		send_word(cpu8alu_pkg::ACT_LDA, 8'h00, 1'b0);
		send_word(cpu8alu_pkg::ACT_LDX, 8'hFF, 1'b0);
		send_word(cpu8alu_pkg::ACT_LDY, 8'h7F, 1'b0);
		send_word(cpu8alu_pkg::ACT_STX, 8'h00, 1'b0);
		send_word(cpu8alu_pkg::ACT_STY, 8'hFF, 1'b0);
		send_word(cpu8alu_pkg::ACT_ORA, 8'h7F, 1'b0);
		send_word(cpu8alu_pkg::ACT_AND, 8'h0F, 1'b0);
		send_word(cpu8alu_pkg::ACT_EOR, 8'hFF, 1'b0);
		send_word(cpu8alu_pkg::ACT_STA, 8'h00, 1'b1);
		send_word(cpu8alu_pkg::ACT_LDA, 8'h7F, 1'b0);
		send_word(cpu8alu_pkg::ACT_ADC, 8'h01, 1'b0);
		send_word(cpu8alu_pkg::ACT_SBC, 8'h01, 1'b0);
		send_word(cpu8alu_pkg::ACT_CMP, 8'h7E, 1'b0);
		send_word(cpu8alu_pkg::ACT_CPX, 8'h00, 1'b0);
		send_word(cpu8alu_pkg::ACT_CPY, 8'h80, 1'b0);
		send_word(cpu8alu_pkg::ACT_ASL, 8'h00, 1'b1);
		send_word(cpu8alu_pkg::ACT_ROL, 8'hFF, 1'b0);
		send_word(cpu8alu_pkg::ACT_LSR, 8'h01, 1'b0);
		send_word(cpu8alu_pkg::ACT_ROR, 8'h00, 1'b1);
		send_word(cpu8alu_pkg::ACT_INC, 8'hFF, 1'b0);
		send_word(cpu8alu_pkg::ACT_DEC, 8'h00, 1'b0);
		send_word(cpu8alu_pkg::ACT_BIT, 8'hC0, 1'b1);
		// unused action code, all ones
		send_word('1, 8'hFF, 1'b1);
		drain();

		reg_write(cpu8alu_pkg::REG_DECIMAL_MODE, cpu8alu_pkg::ApbW'(1));
		send_word(cpu8alu_pkg::ACT_LDA, 8'h99, 1'b0);
		send_word(cpu8alu_pkg::ACT_ADC, 8'h01, 1'b0);
		send_word(cpu8alu_pkg::ACT_SBC, 8'h00, 1'b0);
		send_word(cpu8alu_pkg::ACT_ADC, 8'hFF, 1'b0);
		send_word(cpu8alu_pkg::ACT_SBC, 8'h99, 1'b0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			reg_write(cpu8alu_pkg::REG_DECIMAL_MODE, cpu8alu_pkg::ApbW'(phase % 2));
			sender_idle_on = (phase != 2 && phase != 5);
			receiver_idle_on = sender_idle_on;
			for (int n = 0; n < 300; n++) begin
				send_random(1'(phase % 2));
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cpu8alu_pkg.sv
rtl/core/cpu8_alu_register_execute_top.sv
rtl/core/cpu8alu_checker.sv
bench/cpu8_alu_register_execute_checker.sv
bench/tb_cpu8_alu_register_execute_top.sv
